FILE: design/dndc_pkg.sv
// Shared types, constants and calendar helper functions for the day number date converter.
package dndc_pkg;

   localparam int unsigned DAY_W    = 22;
   localparam int unsigned YEAR_W   = 14;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned MDAY_W   = 5;
   localparam int unsigned REM_W    = 9;
   localparam int unsigned SCALE_W  = 12;
   localparam int unsigned QUOT_W   = 8;
   localparam int unsigned PROD_W   = 25;
   localparam int unsigned DIV25_SHIFT = 17;
   localparam int unsigned RECIP_25 = 5243;
   localparam int unsigned MONTHS   = 12;

   localparam logic signed [63:0] FIRST_DAY     = 64'sd366;
   localparam logic signed [63:0] LAST_DAY      = 64'sd3652424;
   localparam logic signed [63:0] ZERO_FROM_DAY = 64'sd3652500;
   localparam logic signed [63:0] YEAR_MAX      = 64'sd9999;
   localparam logic signed [63:0] CUTOFF_YEAR   = 64'sd70;
   localparam logic signed [63:0] CENTURY_YEARS = 64'sd100;

   localparam logic [DAY_W-1:0]  LAST_DAY_N    = 22'd3652424;
   localparam logic [DAY_W-1:0]  FIRST_DAY_N   = 22'd366;
   localparam logic [DAY_W-1:0]  COMMON_DAYS   = 22'd365;
   localparam logic [YEAR_W-1:0] YEAR_MAX_N    = 14'd9999;
   localparam logic [YEAR_W-1:0] FIRST_YEAR    = 14'd1;
   localparam logic [YEAR_W-1:0] LOW_BASE      = 14'd2000;
   localparam logic [YEAR_W-1:0] HIGH_BASE     = 14'd1900;

   typedef enum logic [1:0] {
      KIND_DATE     = 2'd0,
      KIND_ZERO     = 2'd1,
      KIND_NULL     = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   typedef enum logic {
      OP_DAY_NUMBER = 1'b0,
      OP_BUILD      = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_SEARCH,
      ST_MONTH,
      ST_EMIT
   } state_type;

   // One classified item waiting for the back end.
   typedef struct packed {
      kind_type            kind;
      logic                split;
      logic                build;
      logic [YEAR_W-1:0]   year;
      logic [DAY_W-1:0]    value;
   } entry_type;

   typedef logic [REM_W-1:0] month_end_type [MONTHS-1];

   // Last day of the year of each month but December, common year.
   // Month lengths 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31.
   localparam month_end_type MONTH_END = '{
      9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // Floor division by 25 through a scaled reciprocal, exact for 12-bit inputs.
   function automatic logic [QUOT_W-1:0] div25(input logic [SCALE_W-1:0] x);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(x) * PROD_W'(RECIP_25);
      return prod[PROD_W-1:DIV25_SHIFT];
   endfunction

   function automatic logic mod25_zero(input logic [SCALE_W-1:0] x);
      logic [SCALE_W-1:0] back;
      back = SCALE_W'(div25(x)) * SCALE_W'(25);
      return back == x;
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic by4;
      logic by100;
      logic by400;
      by4   = (y[1:0] == 2'd0);
      by100 = by4 && mod25_zero(y[YEAR_W-1:2]);
      by400 = (y[3:0] == 4'd0) && mod25_zero(SCALE_W'(y[YEAR_W-1:4]));
      return (by4 && !by100) || by400;
   endfunction

   // Day number of January 1 of year y, y from 1 to 9999.
   function automatic logic [DAY_W-1:0] jan1_day(input logic [YEAR_W-1:0] y);
      logic [YEAR_W-1:0]  p;
      logic [SCALE_W-1:0] p4;
      logic [SCALE_W-1:0] p16;
      p   = y - FIRST_YEAR;
      p4  = p[YEAR_W-1:2];
      p16 = SCALE_W'(p[YEAR_W-1:4]);
      return DAY_W'(y) * COMMON_DAYS + DAY_W'(p4) - DAY_W'(div25(p4))
             + DAY_W'(div25(p16)) + DAY_W'(1);
   endfunction

endpackage

FILE: design/dndc_if.sv
// Valid/ready channel interfaces for request and response items of the converter.
interface dndc_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic               argument_null;
   logic signed [63:0] day_value;
   logic signed [63:0] year_value;
   logic signed [63:0] year_day;

   modport source (output valid, operation, argument_null, day_value, year_value, year_day,
                   input ready);
   modport sink   (input valid, operation, argument_null, day_value, year_value, year_day,
                   output ready);
endinterface

interface dndc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [13:0] date_year;
   logic [3:0]  date_month;
   logic [4:0]  date_day;

   modport source (output valid, result_kind, date_year, date_month, date_day,
                   input ready);
   modport sink   (input valid, result_kind, date_year, date_month, date_day,
                   output ready);
endinterface

FILE: design/dndc_front.sv
// Front end: accepts request items and classifies them into queue entries.
module dndc_front (
   dndc_req_if.sink              req_bus,
   input  logic                  queue_full,
   output logic                  push,
   output dndc_pkg::entry_type   push_data
);
   import dndc_pkg::*;

   logic year_bad;
   logic yday_bad;
   logic [YEAR_W-1:0] year_exp;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   assign year_bad = (req_bus.year_value < 64'sd0) || (req_bus.year_value > YEAR_MAX);
   // Anything at or above 2^22 days cannot fit before the last valid date.
   assign yday_bad = (req_bus.year_day <= 64'sd0) || (req_bus.year_day[63:DAY_W] != '0);

   always_comb begin
      if (req_bus.year_value < CUTOFF_YEAR) begin
         year_exp = req_bus.year_value[YEAR_W-1:0] + LOW_BASE;
      end else if (req_bus.year_value < CENTURY_YEARS) begin
         year_exp = req_bus.year_value[YEAR_W-1:0] + HIGH_BASE;
      end else begin
         year_exp = req_bus.year_value[YEAR_W-1:0];
      end
   end

   always_comb begin
      push_data.kind  = KIND_NULL;
      push_data.split = 1'b0;
      push_data.build = 1'b0;
      push_data.year  = year_exp;
      push_data.value = req_bus.day_value[DAY_W-1:0];
      if (req_bus.argument_null) begin
         push_data.kind = KIND_NULL;
      end else if (op_type'(req_bus.operation) == OP_DAY_NUMBER) begin
         if (req_bus.day_value < FIRST_DAY || req_bus.day_value >= ZERO_FROM_DAY) begin
            push_data.kind = KIND_ZERO;
         end else if (req_bus.day_value > LAST_DAY) begin
            push_data.kind = KIND_OVERFLOW;
         end else begin
            push_data.kind  = KIND_DATE;
            push_data.split = 1'b1;
         end
      end else if (!year_bad && !yday_bad) begin
         push_data.kind  = KIND_DATE;
         push_data.split = 1'b1;
         push_data.build = 1'b1;
         push_data.value = req_bus.year_day[DAY_W-1:0];
      end
   end

endmodule

FILE: design/dndc_queue.sv
// Two-entry queue that decouples the classifier from the date unit.
module dndc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dndc_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output dndc_pkg::entry_type pop_data,
   output logic                empty
);
   import dndc_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_in;
   logic [1:0] count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/dndc_back.sv
// Back end: binary year search, month split and the registered response stage.
module dndc_back (
   input  logic                clock,
   input  logic                reset,
   output logic                pop,
   input  dndc_pkg::entry_type pop_data,
   input  logic                empty,
   dndc_rsp_if.source          rsp_bus
);
   import dndc_pkg::*;

   state_type          st_ff,    st_in;
   kind_type           kind_ff,  kind_in;
   logic [DAY_W-1:0]   dn_ff,    dn_in;
   logic [DAY_W-1:0]   jan_ff,   jan_in;
   logic [YEAR_W-1:0]  lo_ff,    lo_in;
   logic [YEAR_W-1:0]  hi_ff,    hi_in;
   logic [YEAR_W-1:0]  year_ff,  year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [MDAY_W-1:0]  mday_ff,  mday_in;
   logic               out_valid_ff, out_valid_in;
   kind_type           out_kind_ff,  out_kind_in;
   logic [YEAR_W-1:0]  out_year_ff,  out_year_in;
   logic [MONTH_W-1:0] out_month_ff, out_month_in;
   logic [MDAY_W-1:0]  out_mday_ff,  out_mday_in;

   logic [YEAR_W:0]    mid_sum;
   logic [YEAR_W-1:0]  mid;
   logic [DAY_W-1:0]   mid_jan;
   logic [DAY_W-1:0]   limit;
   logic [DAY_W-1:0]   rem_full;
   logic [REM_W-1:0]   rem;
   logic [REM_W-1:0]   base;
   logic [REM_W-1:0]   end_adj;
   logic [MONTH_W-1:0] midx;
   logic               leap;
   logic               out_free;

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.result_kind = out_kind_ff;
   assign rsp_bus.date_year   = out_year_ff;
   assign rsp_bus.date_month  = out_month_ff;
   assign rsp_bus.date_day    = out_mday_ff;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[YEAR_W:1];
   assign mid_jan  = jan1_day(mid);
   assign limit    = LAST_DAY_N - jan_ff + DAY_W'(1);
   assign rem_full = dn_ff - jan_ff + DAY_W'(1);
   assign rem      = rem_full[REM_W-1:0];
   assign leap     = is_leap(year_ff);

   // Month index counts the month ends that the day of the year lies past.
   always_comb begin
      midx = '0;
      base = '0;
      for (int m = 0; m < MONTHS - 1; m++) begin
         end_adj = MONTH_END[m] + ((leap && m >= 1) ? REM_W'(1) : REM_W'(0));
         if (rem > end_adj) begin
            midx = MONTH_W'(m + 1);
            base = end_adj;
         end
      end
   end

   always_comb begin
      st_in        = st_ff;
      kind_in      = kind_ff;
      dn_in        = dn_ff;
      jan_in       = jan_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      mday_in      = mday_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_kind_in  = out_kind_ff;
      out_year_in  = out_year_ff;
      out_month_in = out_month_ff;
      out_mday_in  = out_mday_ff;
      pop          = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop     = 1'b1;
               kind_in = pop_data.kind;
               dn_in   = pop_data.value;
               year_in = pop_data.year;
               lo_in   = FIRST_YEAR;
               hi_in   = YEAR_MAX_N;
               jan_in  = FIRST_DAY_N;
               if (pop_data.build) begin
                  st_in = ST_PREP;
               end else if (pop_data.split) begin
                  year_in = FIRST_YEAR;
                  st_in   = ST_SEARCH;
               end else begin
                  st_in = ST_EMIT;
               end
            end
         end
         ST_PREP: begin
            jan_in = jan1_day(year_ff);
            st_in  = ST_CHECK;
         end
         ST_CHECK: begin
            // A day of the year that runs past the last valid date gives null.
            if (dn_ff > limit) begin
               kind_in = KIND_NULL;
               st_in   = ST_EMIT;
            end else begin
               dn_in   = jan_ff + dn_ff - DAY_W'(1);
               lo_in   = FIRST_YEAR;
               hi_in   = YEAR_MAX_N;
               year_in = FIRST_YEAR;
               jan_in  = FIRST_DAY_N;
               st_in   = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (lo_ff > hi_ff) begin
               st_in = ST_MONTH;
            end else if (mid_jan <= dn_ff) begin
               year_in = mid;
               jan_in  = mid_jan;
               lo_in   = mid + FIRST_YEAR;
            end else begin
               hi_in = mid - FIRST_YEAR;
            end
         end
         ST_MONTH: begin
            month_in = midx + MONTH_W'(1);
            mday_in  = MDAY_W'(rem - base);
            st_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = kind_ff;
               if (kind_ff == KIND_DATE) begin
                  out_year_in  = year_ff;
                  out_month_in = month_ff;
                  out_mday_in  = mday_ff;
               end else begin
                  out_year_in  = '0;
                  out_month_in = '0;
                  out_mday_in  = '0;
               end
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      dn_ff        <= dn_in;
      jan_ff       <= jan_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      year_ff      <= year_in;
      month_ff     <= month_in;
      mday_ff      <= mday_in;
      out_kind_ff  <= out_kind_in;
      out_year_ff  <= out_year_in;
      out_month_ff <= out_month_in;
      out_mday_ff  <= out_mday_in;
   end

endmodule

FILE: design/day_number_date_converter_core.sv
// Top level of the proleptic Gregorian day number to date converter.
// Each request item gives exactly one response item, in order. A request that
// resolves to a date (a day number from 366 to 3652424, or a valid year and day
// of the year) runs a binary search for the year of 13 or 14 steps, one step a
// cycle, then splits month and day in a further state; when it is built from a
// year and a day of the year, the January 1 day number is computed and range
// checked first. Items that give the zero date, null or the overflow null skip
// the search, and a year and day of the year that runs past the last valid date
// gives null after the range check. The iterative year search in the date unit
// sets the rate; the date unit pops a new item only after the last one has gone
// to the output register. A two-entry queue sits in front of the date unit, so
// requests keep being taken while a result waits in the output register.
module day_number_date_converter_core (
   input  logic       clock,
   input  logic       reset,
   dndc_req_if.sink   req_bus,
   dndc_rsp_if.source rsp_bus
);
   import dndc_pkg::*;

   entry_type push_data;
   entry_type pop_data;
   logic      push;
   logic      pop;
   logic      full;
   logic      empty;

   dndc_front u_front (
      .req_bus    (req_bus),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   dndc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   dndc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop      (pop),
      .pop_data (pop_data),
      .empty    (empty),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: sim/tb_day_number_date_converter_core.sv
// Self-checking testbench that drives random and edge-case items into the converter.
`timescale 1ns / 1ps

module tb_day_number_date_converter_core;
   import dndc_pkg::*;

   localparam longint DAYS_COMMON    = 365;
   localparam longint YEAR_BASE_LOW  = 2000;
   localparam longint YEAR_BASE_HIGH = 1900;
   localparam int     IDLE_PERCENT   = 17;
   localparam int     STEADY_FROM    = 800;
   localparam int     STEADY_TO      = 1100;
   localparam int     RANDOM_ITEMS   = 1950;
   localparam int     STALL_LIMIT    = 5000;
   localparam int     TAIL_CYCLES    = 40;
   localparam int     REPORT_LIMIT   = 10;

   typedef struct {
      op_type  op;
      logic    arg_null;
      longint  day_num;
      longint  year_arg;
      longint  yday_arg;
      bit      drain_first;
   } conv_req_type;

   typedef struct packed {
      kind_type    kind;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
   } date_out_type;

   logic clock = 1'b0;
   logic reset;

   dndc_req_if req_bus ();
   dndc_rsp_if rsp_bus ();

   day_number_date_converter_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   conv_req_type pending_items[$];
   date_out_type expected_dates[$];
   logic      req_taken = 1'b0;
   int        req_count = 0;
   int        rsp_count = 0;
   int        failures = 0;
   int        quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit year_is_leap(longint y);
      return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
   endfunction

   function automatic longint month_length(int m, longint y);
      case (m)
         2: return year_is_leap(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // Day number of January 1 of year y.
   function automatic longint jan1_of(longint y);
      longint p;
      p = y - 1;
      return y * DAYS_COMMON + p / 4 - p / 100 + p / 400 + 1;
   endfunction

   function automatic date_out_type split_day_number(longint dn);
      date_out_type res;
      longint    y;
      longint    rem;
      int        m;
      // Start below the true year and walk up; the gap is at most a few dozen years.
      y = dn / 366;
      if (y < 1) begin
         y = 1;
      end
      while (y < YEAR_MAX && jan1_of(y + 1) <= dn) begin
         y++;
      end
      rem = dn - jan1_of(y) + 1;
      m = 1;
      while (m < 12 && rem > month_length(m, y)) begin
         rem -= month_length(m, y);
         m++;
      end
      res.kind  = KIND_DATE;
      res.year  = 14'(y);
      res.month = 4'(m);
      res.mday  = 5'(rem);
      return res;
   endfunction

   function automatic date_out_type predict_date(conv_req_type r);
      date_out_type res;
      longint    y;
      longint    j;
      res = '{kind: KIND_NULL, year: '0, month: '0, mday: '0};
      if (r.arg_null) begin
         return res;
      end
      if (r.op == OP_DAY_NUMBER) begin
         if (r.day_num < FIRST_DAY || r.day_num >= ZERO_FROM_DAY) begin
            res.kind = KIND_ZERO;
         end else if (r.day_num > LAST_DAY) begin
            res.kind = KIND_OVERFLOW;
         end else begin
            res = split_day_number(r.day_num);
         end
         return res;
      end
      if (r.year_arg < 0 || r.year_arg > YEAR_MAX || r.yday_arg <= 0) begin
         return res;
      end
      if (r.year_arg < CUTOFF_YEAR) begin
         y = r.year_arg + YEAR_BASE_LOW;
      end else if (r.year_arg < CENTURY_YEARS) begin
         y = r.year_arg + YEAR_BASE_HIGH;
      end else begin
         y = r.year_arg;
      end
      j = jan1_of(y);
      // A date past the last supported day is plain null, with no overflow warning.
      if (r.yday_arg > LAST_DAY - j + 1) begin
         return res;
      end
      return split_day_number(j + r.yday_arg - 1);
   endfunction

   function automatic longint rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic add_item(op_type op, logic arg_null, longint day_num, longint year_arg,
                           longint yday_arg, bit drain_first = 1'b0);
      conv_req_type item;
      item.op          = op;
      item.arg_null    = arg_null;
      item.day_num     = day_num;
      item.year_arg    = year_arg;
      item.yday_arg    = yday_arg;
      item.drain_first = drain_first;
      pending_items.push_back(item);
   endtask

   // Request driver: holds an item until it is taken, then loads the next one.
   always @(negedge clock) begin : drive_requests
      conv_req_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_items.size() != 0
             && !(pending_items[0].drain_first && expected_dates.size() != 0)
             && ((req_count >= STEADY_FROM && req_count < STEADY_TO)
                 || $urandom_range(99) >= IDLE_PERCENT)) begin
            item = pending_items.pop_front();
            req_bus.operation     <= item.op;
            req_bus.argument_null <= item.arg_null;
            req_bus.day_value     <= item.day_num;
            req_bus.year_value    <= item.year_arg;
            req_bus.year_day      <= item.yday_arg;
            req_bus.valid         <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= (rsp_count >= STEADY_FROM && rsp_count < STEADY_TO)
                       || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Every accepted request item gets its expected date queued here.
   always @(posedge clock) begin : watch_requests
      conv_req_type seen;
      req_taken <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen.op          = op_type'(req_bus.operation);
         seen.arg_null    = req_bus.argument_null;
         seen.day_num     = req_bus.day_value;
         seen.year_arg    = req_bus.year_value;
         seen.yday_arg    = req_bus.year_day;
         seen.drain_first = 1'b0;
         expected_dates.push_back(predict_date(seen));
         req_count++;
      end
   end

   always @(posedge clock) begin : check_responses
      date_out_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_dates.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("unexpected result item %0d: kind %0d date %0d-%0d-%0d", rsp_count,
                        rsp_bus.result_kind, rsp_bus.date_year, rsp_bus.date_month,
                        rsp_bus.date_day);
            end
         end else begin
            want = expected_dates.pop_front();
            if (rsp_bus.result_kind !== want.kind || rsp_bus.date_year !== want.year
                || rsp_bus.date_month !== want.month || rsp_bus.date_day !== want.mday) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("mismatch on result item %0d: expected kind %0d date %0d-%0d-%0d,%s",
                           rsp_count, want.kind, want.year, want.month, want.mday,
                           $sformatf(" got kind %0d date %0d-%0d-%0d", rsp_bus.result_kind,
                                     rsp_bus.date_year, rsp_bus.date_month,
                                     rsp_bus.date_day));
               end
            end
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_test
      longint yr;
      longint yd;
      longint dn;
      op_type op;
      logic   nul;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.operation     = OP_DAY_NUMBER;
      req_bus.argument_null = 1'b0;
      req_bus.day_value     = '0;
      req_bus.year_value    = '0;
      req_bus.year_day      = '0;
      rsp_bus.ready         = 1'b0;

      // Day number edges, null argument and the overflow band.
      add_item(OP_DAY_NUMBER, 1'b1, 1000, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, 365, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, 366, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, 3652424, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, 3652425, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, 3652499, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, 3652500, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, 64'sh8000_0000_0000_0000, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, 64'sh7FFF_FFFF_FFFF_FFFF, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, -1, 0, 0);
      add_item(OP_DAY_NUMBER, 1'b0, jan1_of(2000) + 59, 0, 0);
      // Year and day of year: two-digit expansion, bounds and the end of the calendar.
      add_item(OP_BUILD, 1'b1, 0, 2020, 10);
      add_item(OP_BUILD, 1'b0, 0, 0, 1);
      add_item(OP_BUILD, 1'b0, 0, 69, 365);
      add_item(OP_BUILD, 1'b0, 0, 70, 1);
      add_item(OP_BUILD, 1'b0, 0, 99, 365);
      add_item(OP_BUILD, 1'b0, 0, 100, 60);
      add_item(OP_BUILD, 1'b0, 0, 1900, 60);
      add_item(OP_BUILD, 1'b0, 0, 9999, 365);
      add_item(OP_BUILD, 1'b0, 0, 9999, 366);
      add_item(OP_BUILD, 1'b0, 0, -1, 1);
      add_item(OP_BUILD, 1'b0, 0, 10000, 1);
      add_item(OP_BUILD, 1'b0, 0, 2000, 0);
      add_item(OP_BUILD, 1'b0, 0, 64'sh8000_0000_0000_0000, 64'sh7FFF_FFFF_FFFF_FFFF);
      add_item(OP_BUILD, 1'b0, 0, 64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000);
      add_item(OP_BUILD, 1'b0, 0, 100, LAST_DAY - jan1_of(100) + 1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         op  = op_type'($urandom_range(1));
         nul = ($urandom_range(99) < 5);
         dn  = rand64();
         yr  = rand64();
         yd  = rand64();
         if (op == OP_DAY_NUMBER) begin
            case ($urandom_range(99) / 10)
               0: dn = $urandom_range(367, 363);
               1: dn = $urandom_range(3652505, 3652420);
               2: dn = (i % 2 == 0) ? longint'($urandom_range(365)) :
                                      longint'($urandom_range(3652600, 3652425));
               3: dn = -longint'($urandom_range(100000));
               4: ;
               default: dn = $urandom_range(3652424, 366);
            endcase
         end else begin
            case ($urandom_range(99) / 10)
               0: yr = $urandom_range(99);
               1: yr = (i % 2 == 0) ? longint'($urandom_range(10002, 9990)) :
                                      -longint'($urandom_range(3));
               2: ;
               default: yr = $urandom_range(9999, 100);
            endcase
            case ($urandom_range(99) / 10)
               0: yd = -longint'($urandom_range(400));
               1: ;
               2: yd = $urandom_range(3652059, 1);
               3: begin
                  yr = $urandom_range(9999, 9000);
                  yd = LAST_DAY - jan1_of(yr) + longint'($urandom_range(2));
               end
               default: yd = $urandom_range(366, 1);
            endcase
         end
         // Two points in the run where the sender waits for the block to drain.
         add_item(op, nul, dn, yr, yd, i == 0 || i == RANDOM_ITEMS / 2);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_items.size() != 0 || req_bus.valid || expected_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
